// File: sv/i2cms_pkg.sv
// Shared constants, codes and item types for the I2C master sequencer.
package i2cms_pkg;

    // Store depths and derived widths.
    localparam int TX_DEPTH = 16;
    localparam int RX_DEPTH = 16;
    localparam int TX_IDX_W = $clog2(TX_DEPTH);
    localparam int RX_IDX_W = $clog2(RX_DEPTH);
    localparam int RX_PTR_W = $clog2(RX_DEPTH + 1);
    localparam int LEN_W    = 5;

    // Request codes.
    localparam logic [2:0] ACT_LOAD_TX  = 3'd0;
    localparam logic [2:0] ACT_WRITE    = 3'd1;
    localparam logic [2:0] ACT_READ     = 3'd2;
    localparam logic [2:0] ACT_EVENT    = 3'd3;
    localparam logic [2:0] ACT_READ_RX  = 3'd4;

    // Bus status codes.
    localparam logic [3:0] ST_START      = 4'd0;
    localparam logic [3:0] ST_REP_START  = 4'd1;
    localparam logic [3:0] ST_SLAW_ACK   = 4'd2;
    localparam logic [3:0] ST_SLAW_NACK  = 4'd3;
    localparam logic [3:0] ST_MT_ACK     = 4'd4;
    localparam logic [3:0] ST_MT_NACK    = 4'd5;
    localparam logic [3:0] ST_ARB_LOST   = 4'd6;
    localparam logic [3:0] ST_SLAR_ACK   = 4'd7;
    localparam logic [3:0] ST_SLAR_NACK  = 4'd8;
    localparam logic [3:0] ST_MR_ACK     = 4'd9;
    localparam logic [3:0] ST_MR_NACK    = 4'd10;
    localparam logic [3:0] ST_ILLEGAL    = 4'd12;

    // Bus commands.
    localparam logic [2:0] CMD_NONE    = 3'd0;
    localparam logic [2:0] CMD_START   = 3'd1;
    localparam logic [2:0] CMD_STOP    = 3'd2;
    localparam logic [2:0] CMD_SEND    = 3'd3;
    localparam logic [2:0] CMD_RX_ACK  = 3'd4;
    localparam logic [2:0] CMD_RX_NACK = 3'd5;

    // Bus modes, the states of the sequencer.
    typedef enum logic [2:0] {
        MODE_READY   = 3'd0,
        MODE_INIT    = 3'd1,
        MODE_TX      = 3'd2,
        MODE_RX      = 3'd3,
        MODE_REPSENT = 3'd4
    } t_mode;

    // Error codes.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_SUCCESS   = 3'd1;
    localparam logic [2:0] ERR_NOINFO    = 3'd2;
    localparam logic [2:0] ERR_SLAW_NACK = 3'd3;
    localparam logic [2:0] ERR_DATA_NACK = 3'd4;
    localparam logic [2:0] ERR_SLAR_NACK = 3'd5;
    localparam logic [2:0] ERR_ARB_LOST  = 3'd6;
    localparam logic [2:0] ERR_ILLEGAL   = 3'd7;

    // Read bit appended to the slave address.
    localparam logic [7:0] READ_BIT = 8'h01;

    typedef struct packed {
        logic [2:0]       action;
        logic [3:0]       slot;
        logic [7:0]       data_byte;
        logic [LEN_W-1:0] length;
        logic [6:0]       slave_address;
        logic             repeat_start;
        logic [3:0]       bus_status;
    } t_in_item;

    typedef struct packed {
        logic [2:0] bus_command;
        logic [7:0] send_byte;
        logic [2:0] mode;
        logic [2:0] error_code;
        logic       ready_res;
        logic       refused;
        logic [7:0] read_byte;
    } t_out_item;

    // Control from the pipeline to the sequencer core.
    typedef struct packed {
        logic     fire;
        t_in_item item;
    } t_core_req;

endpackage

// File: sv/i2cms_if.sv
// Valid/ready channel interfaces for request and result items.
interface i2cms_in_if;
    logic                valid;
    logic                ready;
    i2cms_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cms_out_if;
    logic                 valid;
    logic                 ready;
    i2cms_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: sv/i2cms_core.sv
// Sequencer state, byte stores and the per-item decision logic.
module i2cms_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  i2cms_pkg::t_core_req i_req,
    output i2cms_pkg::t_out_item o_result
);

    logic [7:0] r_tx_store [i2cms_pkg::TX_DEPTH];
    logic [7:0] r_rx_store [i2cms_pkg::RX_DEPTH];

    logic [i2cms_pkg::LEN_W-1:0]    r_tx_count, n_tx_count;
    logic [i2cms_pkg::LEN_W-1:0]    r_tx_ptr, n_tx_ptr;
    logic [i2cms_pkg::LEN_W-1:0]    r_rx_count, n_rx_count;
    logic [i2cms_pkg::RX_PTR_W-1:0] r_rx_ptr, n_rx_ptr;
    i2cms_pkg::t_mode               r_mode, n_mode;
    logic [2:0]                     r_err, n_err;
    logic                           r_keep, n_keep;

    logic       tx_we;
    logic [i2cms_pkg::TX_IDX_W-1:0] tx_waddr;
    logic [7:0] tx_wdata;
    logic       rx_we;

    // Decide the result and the next state for the item in hand.
    always_comb begin
        i2cms_pkg::t_in_item it;
        logic       was_ready;
        logic [2:0] cmd;
        logic [7:0] sbyte;
        logic       refused;
        logic [7:0] rd;
        logic       do_finish;
        logic [2:0] fin_err;
        logic       do_ask;
        logic       do_send;
        logic [7:0] addr_byte;

        it         = i_req.item;
        was_ready  = r_mode inside {i2cms_pkg::MODE_READY, i2cms_pkg::MODE_REPSENT};
        cmd        = i2cms_pkg::CMD_NONE;
        sbyte      = 8'd0;
        refused    = 1'b0;
        rd         = 8'd0;
        do_finish  = 1'b0;
        fin_err    = i2cms_pkg::ERR_SUCCESS;
        do_ask     = 1'b0;
        do_send    = 1'b0;
        addr_byte  = {it.slave_address, 1'b0} | i2cms_pkg::READ_BIT;

        n_tx_count = r_tx_count;
        n_tx_ptr   = r_tx_ptr;
        n_rx_count = r_rx_count;
        n_rx_ptr   = r_rx_ptr;
        n_mode     = r_mode;
        n_err      = r_err;
        n_keep     = r_keep;

        tx_we      = 1'b0;
        tx_waddr   = i2cms_pkg::TX_IDX_W'(it.slot);
        tx_wdata   = it.data_byte;
        rx_we      = 1'b0;

        case (it.action)
            i2cms_pkg::ACT_LOAD_TX: begin
                tx_we = 32'(it.slot) < i2cms_pkg::TX_DEPTH;
            end
            i2cms_pkg::ACT_WRITE, i2cms_pkg::ACT_READ: begin
                if (!was_ready || (it.action == i2cms_pkg::ACT_WRITE
                                   && 32'(it.length) > i2cms_pkg::TX_DEPTH)
                               || (it.action == i2cms_pkg::ACT_READ
                                   && 32'(it.length) > i2cms_pkg::RX_DEPTH)) begin
                    refused = 1'b1;
                end else begin
                    n_keep   = it.repeat_start;
                    n_tx_ptr = '0;
                    n_mode   = i2cms_pkg::MODE_INIT;
                    if (it.action == i2cms_pkg::ACT_READ) begin
                        // A read sends the address byte as a one-byte write.
                        n_rx_ptr   = '0;
                        n_rx_count = it.length;
                        n_tx_count = i2cms_pkg::LEN_W'(1);
                        tx_we      = 1'b1;
                        tx_waddr   = '0;
                        tx_wdata   = addr_byte;
                    end else begin
                        n_tx_count = it.length;
                    end
                    // After a repeated start the first byte goes out at once.
                    if (r_mode == i2cms_pkg::MODE_REPSENT) begin
                        cmd      = i2cms_pkg::CMD_SEND;
                        n_tx_ptr = i2cms_pkg::LEN_W'(1);
                        sbyte    = (it.action == i2cms_pkg::ACT_READ) ? addr_byte
                                                                      : r_tx_store[0];
                    end else begin
                        cmd = i2cms_pkg::CMD_START;
                    end
                end
            end
            i2cms_pkg::ACT_EVENT: begin
                case (it.bus_status)
                    i2cms_pkg::ST_SLAW_ACK: begin
                        n_mode  = i2cms_pkg::MODE_TX;
                        do_send = 1'b1;
                    end
                    i2cms_pkg::ST_START, i2cms_pkg::ST_MT_ACK: begin
                        do_send = 1'b1;
                    end
                    i2cms_pkg::ST_SLAR_ACK: begin
                        n_mode = i2cms_pkg::MODE_RX;
                        do_ask = 1'b1;
                    end
                    i2cms_pkg::ST_MR_ACK: begin
                        rx_we  = 32'(r_rx_ptr) < i2cms_pkg::RX_DEPTH;
                        do_ask = 1'b1;
                    end
                    i2cms_pkg::ST_MR_NACK: begin
                        rx_we     = 32'(r_rx_ptr) < i2cms_pkg::RX_DEPTH;
                        do_finish = 1'b1;
                    end
                    i2cms_pkg::ST_SLAW_NACK: begin
                        do_finish = 1'b1;
                        fin_err   = i2cms_pkg::ERR_SLAW_NACK;
                    end
                    i2cms_pkg::ST_MT_NACK: begin
                        do_finish = 1'b1;
                        fin_err   = i2cms_pkg::ERR_DATA_NACK;
                    end
                    i2cms_pkg::ST_SLAR_NACK: begin
                        do_finish = 1'b1;
                        fin_err   = i2cms_pkg::ERR_SLAR_NACK;
                    end
                    i2cms_pkg::ST_ARB_LOST: begin
                        do_finish = 1'b1;
                        fin_err   = i2cms_pkg::ERR_ARB_LOST;
                    end
                    i2cms_pkg::ST_REP_START: begin
                        n_mode = i2cms_pkg::MODE_REPSENT;
                    end
                    i2cms_pkg::ST_ILLEGAL: begin
                        n_err  = i2cms_pkg::ERR_ILLEGAL;
                        n_mode = i2cms_pkg::MODE_READY;
                        cmd    = i2cms_pkg::CMD_STOP;
                    end
                    default: begin
                    end
                endcase
            end
            i2cms_pkg::ACT_READ_RX: begin
                if (32'(it.slot) < i2cms_pkg::RX_DEPTH) begin
                    rd = r_rx_store[i2cms_pkg::RX_IDX_W'(it.slot)];
                end
            end
            default: begin
            end
        endcase

        // Transmit the next byte, or close the write when all are sent.
        if (do_send) begin
            if (r_tx_ptr < r_tx_count) begin
                cmd      = i2cms_pkg::CMD_SEND;
                n_tx_ptr = r_tx_ptr + 1'b1;
                n_err    = i2cms_pkg::ERR_NOINFO;
                if (32'(r_tx_ptr) < i2cms_pkg::TX_DEPTH) begin
                    sbyte = r_tx_store[i2cms_pkg::TX_IDX_W'(r_tx_ptr)];
                end
            end else begin
                do_finish = 1'b1;
            end
        end

        // Received bytes advance the pointer until the store is full.
        if (rx_we) begin
            n_rx_ptr = r_rx_ptr + 1'b1;
        end

        // Ask for one more byte; the last one of the read gets a NACK.
        if (do_ask) begin
            n_err = i2cms_pkg::ERR_NOINFO;
            cmd   = (32'(n_rx_ptr) + 1 < 32'(r_rx_count)) ? i2cms_pkg::CMD_RX_ACK
                                                          : i2cms_pkg::CMD_RX_NACK;
        end

        // End of transfer: hold the bus with a new start or release it.
        if (do_finish) begin
            n_err = fin_err;
            if (r_keep) begin
                cmd = i2cms_pkg::CMD_START;
            end else begin
                n_mode = i2cms_pkg::MODE_READY;
                cmd    = i2cms_pkg::CMD_STOP;
            end
        end

        o_result.bus_command = cmd;
        o_result.send_byte   = sbyte;
        o_result.mode        = n_mode;
        o_result.error_code  = n_err;
        o_result.ready_res   = n_mode inside {i2cms_pkg::MODE_READY, i2cms_pkg::MODE_REPSENT};
        o_result.refused     = refused;
        o_result.read_byte   = rd;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tx_count <= '0;
            r_tx_ptr   <= '0;
            r_rx_count <= '0;
            r_rx_ptr   <= '0;
            r_mode     <= i2cms_pkg::MODE_READY;
            r_err      <= i2cms_pkg::ERR_NONE;
            r_keep     <= 1'b0;
        end else if (i_req.fire) begin
            r_tx_count <= n_tx_count;
            r_tx_ptr   <= n_tx_ptr;
            r_rx_count <= n_rx_count;
            r_rx_ptr   <= n_rx_ptr;
            r_mode     <= n_mode;
            r_err      <= n_err;
            r_keep     <= n_keep;
        end
    end

    // Byte stores hold no reset value.
    always_ff @(posedge i_clk) begin
        if (i_req.fire && tx_we) begin
            r_tx_store[tx_waddr] <= tx_wdata;
        end
        if (i_req.fire && rx_we) begin
            r_rx_store[i2cms_pkg::RX_IDX_W'(r_rx_ptr)] <= i_req.item.data_byte;
        end
    end

endmodule

// File: sv/i2c_master_sequencer.sv
// Top level of the I2C master sequencer: input register, core and result register.
//
//   channel  direction  handshake           payload
//   i_in     sink       valid/ready         t_in_item (request or bus event)
//   o_out    source     valid/ready         t_out_item (one result per item)
//
// Each item is held in the input register, is decided there by the core and
// lands in the result register when it fires, that is when the result register
// is free or draining: one item per cycle sustained while the result side does
// not stall. The core's state registers form the only loop. Reset is synchronous
// and clears both valid flags and the sequencer state; the byte stores are not
// cleared. A stalled result stalls the input register, which keeps accepting while it is free.
module i2c_master_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2cms_in_if.sink    i_in,
    i2cms_out_if.source o_out
);

    logic                 r_in_valid;
    i2cms_pkg::t_in_item  r_in;
    logic                 r_out_valid;
    i2cms_pkg::t_out_item r_out;
    i2cms_pkg::t_out_item result;
    i2cms_pkg::t_core_req req;
    logic                 fire;

    // The held item is decided when the result register is free or draining.
    assign fire        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || fire;
    assign req.fire    = fire;
    assign req.item    = r_in;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    i2cms_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .o_result (result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    // A decided item always shows up as a result in the next cycle.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("decided item produced no result");

    // A held item is not lost while the result side stalls.
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !fire) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled item dropped or changed");

    // A refused request issues no bus command.
    a_refused_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && result.refused) |-> (result.bus_command == i2cms_pkg::CMD_NONE))
        else $error("refused request issued a bus command");

    // The ready flag of a result follows its mode.
    a_ready_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.ready_res == ((r_out.mode == i2cms_pkg::MODE_READY)
                                          || (r_out.mode == i2cms_pkg::MODE_REPSENT))))
        else $error("ready flag does not match mode");

endmodule

// File: sim/i2c_master_sequencer_tb.sv
// Self-checking testbench for the I2C master sequencer: directed table, then random transfers.
module i2c_master_sequencer_tb;

    // Codes the package leaves unnamed.
    localparam logic [3:0] ST_NO_INFO = 4'd11;
    localparam logic [3:0] ST_UNUSED  = 4'd15;
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    localparam int N_DIRECTED   = 26;
    localparam int ITEM_TARGET  = 400;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        i2cms_pkg::t_in_item  item;
        logic                 typed;
        i2cms_pkg::t_out_item want;
    } t_plan_row;

    logic clk = 1'b0;
    logic rst_n;

    i2cms_in_if  in_ch();
    i2cms_out_if out_ch();

    i2c_master_sequencer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #1 clk = ~clk;

    // Predicted sequencer state.
    logic [7:0]  sq_tx [i2cms_pkg::TX_DEPTH];
    logic [7:0]  sq_rx [i2cms_pkg::RX_DEPTH];
    bit          tx_known [i2cms_pkg::TX_DEPTH];
    bit          rx_known [i2cms_pkg::RX_DEPTH];
    int unsigned sq_tx_cnt;
    int unsigned sq_tx_ptr;
    int unsigned sq_rx_cnt;
    int unsigned sq_rx_ptr;
    logic [2:0]  sq_mode;
    logic [2:0]  sq_err;
    logic        sq_keep;
    logic [2:0]  sq_last_cmd;

    i2cms_pkg::t_out_item pending_responses [$];
    t_plan_row            plan [N_DIRECTED];

    int errors;
    int n_items;
    int n_checked;
    int n_writes;
    int n_reads;
    int n_refused;
    int n_readbacks;
    int n_dropped;
    int send_calm;
    int quiet_cycles;

    function automatic bit bus_free();
        return sq_mode == i2cms_pkg::MODE_READY || sq_mode == i2cms_pkg::MODE_REPSENT;
    endfunction

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return 0;
        else if (r < 9)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic i2cms_pkg::t_in_item scatter_item();
        i2cms_pkg::t_in_item it;
        it.action        = 3'($urandom_range(0, 7));
        it.slot          = 4'($urandom);
        it.data_byte     = 8'($urandom);
        it.length        = 5'($urandom);
        it.slave_address = 7'($urandom);
        it.repeat_start  = 1'($urandom);
        it.bus_status    = 4'($urandom);
        return it;
    endfunction

    task automatic send_next(inout i2cms_pkg::t_out_item r);
        r.bus_command = i2cms_pkg::CMD_SEND;
        r.send_byte   = (sq_tx_ptr < i2cms_pkg::TX_DEPTH) ? sq_tx[sq_tx_ptr] : 8'h00;
        sq_tx_ptr++;
    endtask

    task automatic close_transfer(input logic [2:0] err, inout i2cms_pkg::t_out_item r);
        sq_err = err;
        if (sq_keep) begin
            r.bus_command = i2cms_pkg::CMD_START;
        end else begin
            sq_mode       = i2cms_pkg::MODE_READY;
            r.bus_command = i2cms_pkg::CMD_STOP;
        end
    endtask

    task automatic ask_byte(inout i2cms_pkg::t_out_item r);
        sq_err        = i2cms_pkg::ERR_NOINFO;
        r.bus_command = (sq_rx_ptr + 1 < sq_rx_cnt) ? i2cms_pkg::CMD_RX_ACK
                                                    : i2cms_pkg::CMD_RX_NACK;
    endtask

    // Bytes past the end of the receive store are dropped.
    task automatic store_rx(input logic [7:0] b);
        if (sq_rx_ptr < i2cms_pkg::RX_DEPTH) begin
            sq_rx[sq_rx_ptr]    = b;
            rx_known[sq_rx_ptr] = 1'b1;
            sq_rx_ptr++;
        end else begin
            n_dropped++;
        end
    endtask

    // A start after a repeated start goes straight to sending slot 0.
    task automatic begin_transfer(input int unsigned len, input logic rep,
                                  inout i2cms_pkg::t_out_item r);
        sq_keep   = rep;
        sq_tx_cnt = len;
        sq_tx_ptr = 0;
        if (sq_mode == i2cms_pkg::MODE_REPSENT) begin
            sq_mode = i2cms_pkg::MODE_INIT;
            send_next(r);
        end else begin
            sq_mode       = i2cms_pkg::MODE_INIT;
            r.bus_command = i2cms_pkg::CMD_START;
        end
    endtask

    // Response of the sequencer to one item, advancing the predicted state.
    task automatic predict_response(input i2cms_pkg::t_in_item it,
                                    output i2cms_pkg::t_out_item r);
        r = '0;
        case (it.action)
            i2cms_pkg::ACT_LOAD_TX: begin
                sq_tx[it.slot]    = it.data_byte;
                tx_known[it.slot] = 1'b1;
            end
            i2cms_pkg::ACT_WRITE: begin
                if (!bus_free() || it.length > i2cms_pkg::TX_DEPTH)
                    r.refused = 1'b1;
                else
                    begin_transfer(32'(it.length), it.repeat_start, r);
            end
            i2cms_pkg::ACT_READ: begin
                if (!bus_free() || it.length > i2cms_pkg::RX_DEPTH) begin
                    r.refused = 1'b1;
                end else begin
                    sq_rx_ptr   = 0;
                    sq_rx_cnt   = 32'(it.length);
                    sq_tx[0]    = {it.slave_address, 1'b0} | i2cms_pkg::READ_BIT;
                    tx_known[0] = 1'b1;
                    begin_transfer(1, it.repeat_start, r);
                end
            end
            i2cms_pkg::ACT_EVENT: begin
                case (it.bus_status)
                    i2cms_pkg::ST_START, i2cms_pkg::ST_SLAW_ACK, i2cms_pkg::ST_MT_ACK: begin
                        if (it.bus_status == i2cms_pkg::ST_SLAW_ACK)
                            sq_mode = i2cms_pkg::MODE_TX;
                        if (sq_tx_ptr < sq_tx_cnt) begin
                            send_next(r);
                            sq_err = i2cms_pkg::ERR_NOINFO;
                        end else begin
                            close_transfer(i2cms_pkg::ERR_SUCCESS, r);
                        end
                    end
                    i2cms_pkg::ST_SLAR_ACK: begin
                        sq_mode = i2cms_pkg::MODE_RX;
                        ask_byte(r);
                    end
                    i2cms_pkg::ST_MR_ACK: begin
                        store_rx(it.data_byte);
                        ask_byte(r);
                    end
                    i2cms_pkg::ST_MR_NACK: begin
                        store_rx(it.data_byte);
                        close_transfer(i2cms_pkg::ERR_SUCCESS, r);
                    end
                    i2cms_pkg::ST_SLAW_NACK: close_transfer(i2cms_pkg::ERR_SLAW_NACK, r);
                    i2cms_pkg::ST_MT_NACK:   close_transfer(i2cms_pkg::ERR_DATA_NACK, r);
                    i2cms_pkg::ST_SLAR_NACK: close_transfer(i2cms_pkg::ERR_SLAR_NACK, r);
                    i2cms_pkg::ST_ARB_LOST:  close_transfer(i2cms_pkg::ERR_ARB_LOST, r);
                    i2cms_pkg::ST_REP_START: sq_mode = i2cms_pkg::MODE_REPSENT;
                    i2cms_pkg::ST_ILLEGAL: begin
                        sq_err        = i2cms_pkg::ERR_ILLEGAL;
                        sq_mode       = i2cms_pkg::MODE_READY;
                        r.bus_command = i2cms_pkg::CMD_STOP;
                    end
                    default: ;
                endcase
            end
            i2cms_pkg::ACT_READ_RX: r.read_byte = sq_rx[it.slot];
            default: ;
        endcase
        r.mode       = sq_mode;
        r.error_code = sq_err;
        r.ready_res  = bus_free();
        sq_last_cmd  = r.bus_command;
    endtask

    // Present one item at the falling edge and hold it until it is taken.
    task automatic drive(input i2cms_pkg::t_in_item it, input bit typed,
                         input i2cms_pkg::t_out_item want);
        int                   gap;
        i2cms_pkg::t_out_item got;
        if (send_calm > 0) begin
            gap = 0;
            send_calm--;
        end else begin
            gap = idle_len();
            if ($urandom_range(0, 39) == 0)
                send_calm = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_response(it, got);
        pending_responses.push_back(typed ? want : got);
        if (it.action <= i2cms_pkg::ACT_READ_RX)
            n_items++;
        if (it.action == i2cms_pkg::ACT_WRITE)
            n_writes++;
        if (it.action == i2cms_pkg::ACT_READ)
            n_reads++;
        if (it.action == i2cms_pkg::ACT_READ_RX)
            n_readbacks++;
        if (got.refused)
            n_refused++;
        @(negedge clk);
    endtask

    // Never let a store entry be read before something was written there.
    task automatic put(input i2cms_pkg::t_in_item it);
        i2cms_pkg::t_in_item fill;
        int                  idx;
        bit                  hole;
        hole = 1'b0;
        idx  = 0;
        if (it.action == i2cms_pkg::ACT_EVENT && sq_tx_ptr < sq_tx_cnt &&
            (it.bus_status == i2cms_pkg::ST_START || it.bus_status == i2cms_pkg::ST_SLAW_ACK ||
             it.bus_status == i2cms_pkg::ST_MT_ACK)) begin
            idx  = sq_tx_ptr;
            hole = !tx_known[idx];
        end else if (it.action == i2cms_pkg::ACT_WRITE && sq_mode == i2cms_pkg::MODE_REPSENT &&
                     it.length <= i2cms_pkg::TX_DEPTH) begin
            hole = !tx_known[0];
        end
        if (hole) begin
            fill        = scatter_item();
            fill.action = i2cms_pkg::ACT_LOAD_TX;
            fill.slot   = 4'(idx);
            drive(fill, 1'b0, '0);
        end
        if (it.action == i2cms_pkg::ACT_READ_RX && !rx_known[it.slot])
            it.action = i2cms_pkg::ACT_LOAD_TX;
        drive(it, 1'b0, '0);
    endtask

    // One write or read, answered the way a well-behaved bus would, with
    // occasional NACKs, lost arbitration, busy requests and receive overruns.
    task automatic run_transfer(input bit is_read);
        i2cms_pkg::t_in_item it;
        int                  guard;
        int                  extra;
        int                  r;
        bit                  opened;
        logic [3:0]          st;
        if (!is_read) begin
            repeat ($urandom_range(0, 3)) begin
                it        = scatter_item();
                it.action = i2cms_pkg::ACT_LOAD_TX;
                put(it);
            end
        end
        if (!bus_free()) begin
            it            = scatter_item();
            it.action     = i2cms_pkg::ACT_EVENT;
            it.bus_status = i2cms_pkg::ST_ILLEGAL;
            put(it);
        end
        opened    = (sq_mode == i2cms_pkg::MODE_REPSENT);
        extra     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 20) : 0;
        it        = scatter_item();
        it.action = is_read ? i2cms_pkg::ACT_READ : i2cms_pkg::ACT_WRITE;
        r         = $urandom_range(0, 9);
        if (r < 6)
            it.length = 5'($urandom_range(0, 4));
        else if (r < 9)
            it.length = 5'($urandom_range(5, 16));
        else
            it.length = 5'($urandom_range(17, 31));
        put(it);

        guard = 0;
        while (!bus_free() && guard < 64) begin
            case (sq_last_cmd)
                i2cms_pkg::CMD_START: begin
                    st     = opened ? i2cms_pkg::ST_REP_START : i2cms_pkg::ST_START;
                    opened = 1'b1;
                end
                i2cms_pkg::CMD_SEND: begin
                    if (sq_mode == i2cms_pkg::MODE_INIT)
                        st = is_read ? i2cms_pkg::ST_SLAR_ACK : i2cms_pkg::ST_SLAW_ACK;
                    else
                        st = i2cms_pkg::ST_MT_ACK;
                end
                i2cms_pkg::CMD_RX_ACK: st = i2cms_pkg::ST_MR_ACK;
                i2cms_pkg::CMD_RX_NACK: begin
                    if (extra > 0) begin
                        st = i2cms_pkg::ST_MR_ACK;
                        extra--;
                    end else begin
                        st = i2cms_pkg::ST_MR_NACK;
                    end
                end
                default: st = i2cms_pkg::ST_ILLEGAL;
            endcase
            if ($urandom_range(0, 19) == 0) begin
                case (sq_mode)
                    i2cms_pkg::MODE_INIT:
                        st = is_read ? i2cms_pkg::ST_SLAR_NACK : i2cms_pkg::ST_SLAW_NACK;
                    i2cms_pkg::MODE_TX: st = i2cms_pkg::ST_MT_NACK;
                    default:            st = i2cms_pkg::ST_ARB_LOST;
                endcase
            end
            if ($urandom_range(0, 24) == 0) begin
                it        = scatter_item();
                it.action = $urandom_range(0, 1) ? i2cms_pkg::ACT_WRITE : i2cms_pkg::ACT_READ;
                put(it);
            end
            it            = scatter_item();
            it.action     = i2cms_pkg::ACT_EVENT;
            it.bus_status = st;
            put(it);
            guard++;
        end

        if (is_read) begin
            repeat ($urandom_range(1, 4)) begin
                it        = scatter_item();
                it.action = i2cms_pkg::ACT_READ_RX;
                put(it);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk) begin : check_responses
        i2cms_pkg::t_out_item seen;
        i2cms_pkg::t_out_item want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            seen = out_ch.data;
            n_checked++;
            if (pending_responses.size() == 0) begin
                errors++;
                $display("%0t: unexpected response, expected none, actual %0h",
                         $time, seen);
            end else begin
                want = pending_responses.pop_front();
                check_field("bus_command", 8'(want.bus_command), 8'(seen.bus_command));
                check_field("send_byte", want.send_byte, seen.send_byte);
                check_field("mode", 8'(want.mode), 8'(seen.mode));
                check_field("error_code", 8'(want.error_code), 8'(seen.error_code));
                check_field("ready_res", 8'(want.ready_res), 8'(seen.ready_res));
                check_field("refused", 8'(want.refused), 8'(seen.refused));
                check_field("read_byte", want.read_byte, seen.read_byte);
            end
        end
    end

    // Cycles in which neither channel moved an item.
    always @(posedge clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: random stalls, with calm stretches where it never stalls.
    initial begin : result_sink
        int stall;
        int calm;
        out_ch.ready = 1'b0;
        stall        = 0;
        calm         = 0;
        forever begin
            @(negedge clk);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                stall--;
            end else begin
                out_ch.ready <= 1'b1;
                if (calm > 0)
                    calm--;
                else if ($urandom_range(0, 39) == 0)
                    calm = $urandom_range(20, 60);
                else
                    stall = idle_len();
            end
        end
    end

    initial begin : stimulus
        int k;
        rst_n        = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        n_items      = 0;
        n_writes     = 0;
        n_reads      = 0;
        n_refused    = 0;
        n_readbacks  = 0;
        n_dropped    = 0;
        send_calm    = 0;
        sq_tx_cnt    = 0;
        sq_tx_ptr    = 0;
        sq_rx_cnt    = 0;
        sq_rx_ptr    = 0;
        sq_mode      = i2cms_pkg::MODE_READY;
        sq_err       = i2cms_pkg::ERR_NONE;
        sq_keep      = 1'b0;
        sq_last_cmd  = i2cms_pkg::CMD_NONE;
        foreach (tx_known[i])
            tx_known[i] = 1'b0;
        foreach (rx_known[i])
            rx_known[i] = 1'b0;

        // action, slot, data, length, address, repeat, status | typed | response
        plan = '{
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, ST_NO_INFO},
              1'b1,
              '{i2cms_pkg::CMD_NONE, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_NONE,
                1'b1, 1'b0, 8'h00}},
            '{'{i2cms_pkg::ACT_WRITE, 4'd0, 8'h00, 5'd17, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b1,
              '{i2cms_pkg::CMD_NONE, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_NONE,
                1'b1, 1'b1, 8'h00}},
            '{'{i2cms_pkg::ACT_READ, 4'd0, 8'h00, 5'd31, 7'd127, 1'b1, i2cms_pkg::ST_START},
              1'b1,
              '{i2cms_pkg::CMD_NONE, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_NONE,
                1'b1, 1'b1, 8'h00}},
            '{'{i2cms_pkg::ACT_LOAD_TX, 4'd0, 8'hFF, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_LOAD_TX, 4'd1, 8'hA5, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_LOAD_TX, 4'd15, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_WRITE, 4'd0, 8'h00, 5'd2, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b1,
              '{i2cms_pkg::CMD_START, 8'h00, i2cms_pkg::MODE_INIT, i2cms_pkg::ERR_NONE,
                1'b0, 1'b0, 8'h00}},
            '{'{i2cms_pkg::ACT_WRITE, 4'd0, 8'h00, 5'd0, 7'd0, 1'b1, i2cms_pkg::ST_START},
              1'b1,
              '{i2cms_pkg::CMD_NONE, 8'h00, i2cms_pkg::MODE_INIT, i2cms_pkg::ERR_NONE,
                1'b0, 1'b1, 8'h00}},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'hFF, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_SLAW_ACK},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_MT_ACK},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_READ, 4'd0, 8'h00, 5'd0, 7'd127, 1'b1, i2cms_pkg::ST_START},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_SLAR_ACK},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'hC3, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_MR_NACK},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_REP_START},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_WRITE, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_MT_ACK},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_READ_RX, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b0, '0},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_SLAW_NACK},
              1'b1,
              '{i2cms_pkg::CMD_STOP, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_SLAW_NACK,
                1'b1, 1'b0, 8'h00}},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_MT_NACK},
              1'b1,
              '{i2cms_pkg::CMD_STOP, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_DATA_NACK,
                1'b1, 1'b0, 8'h00}},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_SLAR_NACK},
              1'b1,
              '{i2cms_pkg::CMD_STOP, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_SLAR_NACK,
                1'b1, 1'b0, 8'h00}},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_ARB_LOST},
              1'b1,
              '{i2cms_pkg::CMD_STOP, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_ARB_LOST,
                1'b1, 1'b0, 8'h00}},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_ILLEGAL},
              1'b1,
              '{i2cms_pkg::CMD_STOP, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_ILLEGAL,
                1'b1, 1'b0, 8'h00}},
            '{'{i2cms_pkg::ACT_EVENT, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, ST_UNUSED},
              1'b1,
              '{i2cms_pkg::CMD_NONE, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_ILLEGAL,
                1'b1, 1'b0, 8'h00}},
            '{'{ACT_UNUSED, 4'd0, 8'h00, 5'd0, 7'd0, 1'b0, i2cms_pkg::ST_START},
              1'b1,
              '{i2cms_pkg::CMD_NONE, 8'h00, i2cms_pkg::MODE_READY, i2cms_pkg::ERR_ILLEGAL,
                1'b1, 1'b0, 8'h00}}
        };

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table first.
        foreach (plan[i])
            drive(plan[i].item, plan[i].typed, plan[i].want);

        // Random transfers, with some unstructured items mixed in.
        while (n_items < ITEM_TARGET) begin
            k = $urandom_range(0, 9);
            if (k < 4) begin
                run_transfer(1'b0);
            end else if (k < 8) begin
                run_transfer(1'b1);
            end else begin
                repeat ($urandom_range(1, 4))
                    put(scatter_item());
            end
        end
        in_ch.valid <= 1'b0;

        // Drain the remaining responses, then give the pipeline time to settle.
        while (pending_responses.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d items: %0d write and %0d read requests, %0d refused, %0d readbacks.",
                 n_items, n_writes, n_reads, n_refused, n_readbacks);
        $display("Checked %0d responses; %0d received bytes overran the store; %0d mismatches.",
                 n_checked, n_dropped, errors);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
